@@ design/mvma_pkg.sv @@
// shared constants, types and codes for the matrix-vector multiply-accumulate unit
package mvma_pkg;

    localparam int MAX_COLS   = 256;
    localparam int LANES      = 4;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int LANE_W     = $clog2(LANES);
    localparam int BANK_DEPTH = MAX_COLS / LANES;
    localparam int BANK_AW    = COL_W - LANE_W;

    localparam int ELEM_W     = 16;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int ACC_W      = 48;
    localparam int ACC_HALF   = ACC_W / 2;
    localparam int Y_W        = 32;
    localparam int ROW_W      = 16;
    localparam int FRAC_SHIFT = 8;

    localparam int P_HI_W     = COEF_W + ACC_HALF;
    localparam int P_LO_W     = COEF_W + ACC_HALF + 1;
    localparam int P_Y_W      = COEF_W + Y_W;
    localparam int WIDE_W     = ACC_W + COEF_W + 2;
    localparam int SH_W       = WIDE_W - FRAC_SHIFT;

    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA  = 1'b1;

    localparam logic signed [COEF_W-1:0] ALPHA_RESET = 16'sd256;
    localparam logic signed [COEF_W-1:0] BETA_RESET  = 16'sd0;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_ROW  = 1'b1
    } op_t;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic             valid;
        op_t              op;
        logic             last;
        logic [ROW_W-1:0] row;
    } ctl_t;

endpackage

@@ design/mvma_chan_if.sv @@
// handshake channel interfaces for item, result and configuration beats
interface mvma_item_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic [mvma_pkg::COL_W-1:0]          col_base;
    logic signed [mvma_pkg::ELEM_W-1:0]  elem0;
    logic signed [mvma_pkg::ELEM_W-1:0]  elem1;
    logic signed [mvma_pkg::ELEM_W-1:0]  elem2;
    logic signed [mvma_pkg::ELEM_W-1:0]  elem3;
    logic signed [mvma_pkg::Y_W-1:0]     y_old;
    logic                                row_last;

    modport source (
        output valid, opcode, col_base, elem0, elem1, elem2, elem3, y_old, row_last,
        input  ready
    );
    modport sink (
        input  valid, opcode, col_base, elem0, elem1, elem2, elem3, y_old, row_last,
        output ready
    );
endinterface

interface mvma_result_if;
    logic                             valid;
    logic                             ready;
    logic signed [mvma_pkg::Y_W-1:0]  y_new;
    logic [mvma_pkg::ROW_W-1:0]       row_number;
    logic                             saturated;

    modport source (
        output valid, y_new, row_number, saturated,
        input  ready
    );
    modport sink (
        input  valid, y_new, row_number, saturated,
        output ready
    );
endinterface

interface mvma_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mvma_pkg::CFG_IDX_W-1:0]      index;
    logic [mvma_pkg::COEF_W-1:0]         data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ design/mvma_xbank.sv @@
// one bank of the x vector store, one write and one registered read per cycle
module mvma_xbank (
    input  logic                             clk,
    input  logic                             we,
    input  logic [mvma_pkg::BANK_AW-1:0]     waddr,
    input  logic signed [mvma_pkg::ELEM_W-1:0] wdata,
    input  logic                             re,
    input  logic [mvma_pkg::BANK_AW-1:0]     raddr,
    output logic signed [mvma_pkg::ELEM_W-1:0] rdata
);

    logic signed [mvma_pkg::ELEM_W-1:0] mem [mvma_pkg::BANK_DEPTH];
    logic signed [mvma_pkg::ELEM_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/mvma_lane.sv @@
// one multiply lane: matrix element times stored x element, registered
module mvma_lane (
    input  logic            clk,
    input  logic            en,
    input  mvma_pkg::elem_t elem,
    input  mvma_pkg::elem_t xval,
    output mvma_pkg::prod_t prod
);

    mvma_pkg::prod_t prod_reg;
    mvma_pkg::prod_t prod_next;

    assign prod_next = mvma_pkg::PROD_W'(elem) * mvma_pkg::PROD_W'(xval);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

@@ design/mvma_merge.sv @@
// lane sum into the row accumulator, alpha/beta scaling, rounding, saturation, result register
module mvma_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  mvma_pkg::ctl_t                      ctl,
    input  mvma_pkg::prod_t                     prod [mvma_pkg::LANES],
    input  logic signed [mvma_pkg::Y_W-1:0]     y_old,
    input  logic signed [mvma_pkg::COEF_W-1:0]  alpha,
    input  logic signed [mvma_pkg::COEF_W-1:0]  beta,
    output logic                                res_valid,
    output logic signed [mvma_pkg::Y_W-1:0]     y_new,
    output logic [mvma_pkg::ROW_W-1:0]          row_number,
    output logic                                saturated
);

    localparam logic signed [mvma_pkg::WIDE_W-1:0] ROUND_ADD =
        mvma_pkg::WIDE_W'(1) <<< (mvma_pkg::FRAC_SHIFT - 1);

    // accumulate stage
    logic signed [mvma_pkg::ACC_W-1:0]  lane_sum;
    logic signed [mvma_pkg::ACC_W-1:0]  acc_sum;
    logic signed [mvma_pkg::ACC_W-1:0]  acc_reg;
    logic                               s3_valid_reg;
    logic signed [mvma_pkg::ACC_W-1:0]  s3_acc_reg;
    logic signed [mvma_pkg::Y_W-1:0]    s3_yold_reg;
    logic [mvma_pkg::ROW_W-1:0]         s3_row_reg;

    // scaling stage
    logic signed [mvma_pkg::ACC_HALF-1:0] acc_hi;
    logic signed [mvma_pkg::ACC_HALF:0]   acc_lo;
    logic                               s4_valid_reg;
    logic signed [mvma_pkg::P_HI_W-1:0] s4_phi_reg;
    logic signed [mvma_pkg::P_LO_W-1:0] s4_plo_reg;
    logic signed [mvma_pkg::P_Y_W-1:0]  s4_py_reg;
    logic [mvma_pkg::ROW_W-1:0]         s4_row_reg;

    // sum stage
    logic signed [mvma_pkg::WIDE_W-1:0] wide_next;
    logic                               s5_valid_reg;
    logic signed [mvma_pkg::WIDE_W-1:0] s5_wide_reg;
    logic [mvma_pkg::ROW_W-1:0]         s5_row_reg;

    // round and clamp
    logic signed [mvma_pkg::SH_W-1:0]   shifted;
    logic                               fits;
    logic signed [mvma_pkg::Y_W-1:0]    y_next;
    logic                               out_valid_reg;
    logic signed [mvma_pkg::Y_W-1:0]    y_reg;
    logic [mvma_pkg::ROW_W-1:0]         row_reg;
    logic                               sat_reg;

    always_comb
    begin
        lane_sum = '0;
        for (int k = 0; k < mvma_pkg::LANES; k++)
        begin
            lane_sum = lane_sum + mvma_pkg::ACC_W'(prod[k]);
        end
    end

    assign acc_sum = acc_reg + lane_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (ctl.valid && ctl.op == mvma_pkg::OP_ROW)
            begin
                acc_reg <= ctl.last ? '0 : acc_sum;
            end
            s3_valid_reg  <= ctl.valid && ctl.op == mvma_pkg::OP_ROW && ctl.last;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
        end
    end

    assign acc_hi = s3_acc_reg[mvma_pkg::ACC_W-1:mvma_pkg::ACC_HALF];
    assign acc_lo = {1'b0, s3_acc_reg[mvma_pkg::ACC_HALF-1:0]};

    assign wide_next = (mvma_pkg::WIDE_W'(s4_phi_reg) <<< mvma_pkg::ACC_HALF)
                     + mvma_pkg::WIDE_W'(s4_plo_reg)
                     + mvma_pkg::WIDE_W'(s4_py_reg)
                     + ROUND_ADD;

    assign shifted = s5_wide_reg[mvma_pkg::WIDE_W-1:mvma_pkg::FRAC_SHIFT];
    assign fits    = (&shifted[mvma_pkg::SH_W-1:mvma_pkg::Y_W-1])
                   || !(|shifted[mvma_pkg::SH_W-1:mvma_pkg::Y_W-1]);

    always_comb
    begin
        if (fits)
        begin
            y_next = shifted[mvma_pkg::Y_W-1:0];
        end
        else if (shifted[mvma_pkg::SH_W-1])
        begin
            y_next = {1'b1, {(mvma_pkg::Y_W-1){1'b0}}};
        end
        else
        begin
            y_next = {1'b0, {(mvma_pkg::Y_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_acc_reg  <= acc_sum;
            s3_yold_reg <= y_old;
            s3_row_reg  <= ctl.row;

            s4_phi_reg  <= mvma_pkg::P_HI_W'(alpha) * mvma_pkg::P_HI_W'(acc_hi);
            s4_plo_reg  <= mvma_pkg::P_LO_W'(alpha) * mvma_pkg::P_LO_W'(acc_lo);
            s4_py_reg   <= mvma_pkg::P_Y_W'(beta) * mvma_pkg::P_Y_W'(s3_yold_reg);
            s4_row_reg  <= s3_row_reg;

            s5_wide_reg <= wide_next;
            s5_row_reg  <= s4_row_reg;

            y_reg       <= y_next;
            row_reg     <= s5_row_reg;
            sat_reg     <= !fits;
        end
    end

    assign res_valid  = out_valid_reg;
    assign y_new      = y_reg;
    assign row_number = row_reg;
    assign saturated  = sat_reg;

endmodule

@@ design/matrix_vector_multiply_accumulate_unit.sv @@
// top level: x store banks, multiply lanes and merge pipeline of the gemv unit
// a row's last beat raises result.valid after the s1, s2, s3, s4, s5 and output registers; other beats give none
// one item beat per cycle; the pipeline holds, and item.ready drops, only while a
// finished result waits on result.ready
// reset clears the pipeline, accumulator and row counter, alpha to 1.0, beta to 0;
// the x store is not cleared and holds nothing valid until loaded
module matrix_vector_multiply_accumulate_unit (
    input  logic          clk,
    input  logic          rst_n,
    mvma_item_if.sink     item,
    mvma_result_if.source result,
    mvma_cfg_if.sink      cfg
);

    logic                                   adv;
    logic                                   take;
    logic                                   res_valid;
    logic signed [mvma_pkg::COEF_W-1:0]     alpha_reg;
    logic signed [mvma_pkg::COEF_W-1:0]     beta_reg;
    logic [mvma_pkg::ROW_W-1:0]             row_cnt_reg;
    mvma_pkg::elem_t                        in_elem [mvma_pkg::LANES];
    mvma_pkg::elem_t                        bank_q  [mvma_pkg::LANES];
    mvma_pkg::prod_t                        prod    [mvma_pkg::LANES];

    mvma_pkg::ctl_t                         s1_ctl_reg;
    mvma_pkg::ctl_t                         s1_ctl_next;
    mvma_pkg::ctl_t                         s2_ctl_reg;
    mvma_pkg::elem_t                        s1_elem_reg [mvma_pkg::LANES];
    logic [mvma_pkg::LANE_W-1:0]            s1_rot_reg;
    logic signed [mvma_pkg::Y_W-1:0]        s1_yold_reg;
    logic signed [mvma_pkg::Y_W-1:0]        s2_yold_reg;

    assign adv        = !res_valid || result.ready;
    assign take       = item.valid && adv;
    assign item.ready = adv;
    assign cfg.ready  = 1'b1;

    assign in_elem[0] = item.elem0;
    assign in_elem[1] = item.elem1;
    assign in_elem[2] = item.elem2;
    assign in_elem[3] = item.elem3;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= mvma_pkg::ALPHA_RESET;
            beta_reg  <= mvma_pkg::BETA_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                mvma_pkg::REG_ALPHA: alpha_reg <= cfg.data;
                mvma_pkg::REG_BETA:  beta_reg  <= cfg.data;
                default:             alpha_reg <= alpha_reg;
            endcase
        end
    end

    // row counter, tagged onto each beat at acceptance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
        end
        else if (take)
        begin
            if (item.opcode == mvma_pkg::OP_LOAD)
            begin
                row_cnt_reg <= '0;
            end
            else if (item.row_last)
            begin
                row_cnt_reg <= row_cnt_reg + mvma_pkg::ROW_W'(1);
            end
        end
    end

    // bank b holds columns with b in the low bits; lanes rotate onto banks by col_base
    for (genvar b = 0; b < mvma_pkg::LANES; b++)
    begin : g_bank
        logic [mvma_pkg::LANE_W-1:0] lane_sel;
        logic [mvma_pkg::COL_W-1:0]  col;

        assign lane_sel = mvma_pkg::LANE_W'(b) - item.col_base[mvma_pkg::LANE_W-1:0];
        assign col      = item.col_base + mvma_pkg::COL_W'(lane_sel);

        mvma_xbank u_bank (
            .clk   (clk),
            .we    (take && item.opcode == mvma_pkg::OP_LOAD),
            .waddr (col[mvma_pkg::COL_W-1:mvma_pkg::LANE_W]),
            .wdata (in_elem[lane_sel]),
            .re    (adv),
            .raddr (col[mvma_pkg::COL_W-1:mvma_pkg::LANE_W]),
            .rdata (bank_q[b])
        );
    end

    always_comb
    begin
        s1_ctl_next.valid = item.valid;
        s1_ctl_next.op    = mvma_pkg::op_t'(item.opcode);
        s1_ctl_next.last  = item.row_last;
        s1_ctl_next.row   = row_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s1_ctl_reg <= s1_ctl_next;
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_elem_reg <= in_elem;
            s1_rot_reg  <= item.col_base[mvma_pkg::LANE_W-1:0];
            s1_yold_reg <= item.y_old;
            s2_yold_reg <= s1_yold_reg;
        end
    end

    for (genvar k = 0; k < mvma_pkg::LANES; k++)
    begin : g_lane
        logic [mvma_pkg::LANE_W-1:0] bank_sel;

        assign bank_sel = s1_rot_reg + mvma_pkg::LANE_W'(k);

        mvma_lane u_lane (
            .clk  (clk),
            .en   (adv),
            .elem (s1_elem_reg[k]),
            .xval (bank_q[bank_sel]),
            .prod (prod[k])
        );
    end

    mvma_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .ctl        (s2_ctl_reg),
        .prod       (prod),
        .y_old      (s2_yold_reg),
        .alpha      (alpha_reg),
        .beta       (beta_reg),
        .res_valid  (res_valid),
        .y_new      (result.y_new),
        .row_number (result.row_number),
        .saturated  (result.saturated)
    );

    assign result.valid = res_valid;

endmodule

@@ tb/sv/tb_matrix_vector_multiply_accumulate_unit.sv @@
// testbench for the gemv unit: directed and random beats checked against a predictor
module tb_matrix_vector_multiply_accumulate_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned PIPE_SETTLE  = 8;
    localparam int unsigned RANDOM_BEATS = 850;
    localparam int unsigned QUIET_TAIL   = 120;

    localparam mvma_pkg::elem_t E_MIN = 16'sh8000;
    localparam mvma_pkg::elem_t E_MAX = 16'sh7fff;
    localparam logic signed [mvma_pkg::COEF_W-1:0] C_MIN = 16'sh8000;
    localparam logic signed [mvma_pkg::COEF_W-1:0] C_MAX = 16'sh7fff;
    localparam logic signed [mvma_pkg::Y_W-1:0] Y_MIN = 32'sh80000000;
    localparam logic signed [mvma_pkg::Y_W-1:0] Y_MAX = 32'sh7fffffff;
    localparam longint CLAMP_HI = (longint'(1) <<< 31) - 1;
    localparam longint CLAMP_LO = -(longint'(1) <<< 31);

    typedef struct {
        logic signed [mvma_pkg::Y_W-1:0] y_new;
        logic [mvma_pkg::ROW_W-1:0]      row_number;
        logic                            saturated;
    } row_result_t;

    logic clk;
    logic rst_n;

    mvma_item_if   item_bus();
    mvma_result_if result_bus();
    mvma_cfg_if    cfg_bus();

    matrix_vector_multiply_accumulate_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // predictor state
    mvma_pkg::elem_t                    x_shadow [mvma_pkg::MAX_COLS];
    bit                                 x_written [mvma_pkg::MAX_COLS];
    logic signed [mvma_pkg::ACC_W-1:0]  row_acc;
    logic [mvma_pkg::ROW_W-1:0]         row_count;
    logic signed [mvma_pkg::COEF_W-1:0] alpha_q;
    logic signed [mvma_pkg::COEF_W-1:0] beta_q;

    row_result_t   y_expect_q [$];
    int unsigned   fail_count;
    int unsigned   beats_sent;
    int unsigned   cycle_count;
    bit            src_gaps;
    bit            snk_gaps;
    logic [mvma_pkg::COL_W-1:0] last_load_base;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL matrix_vector_multiply_accumulate_unit");
            $finish;
        end
    end

    function automatic void apply_gemv_beat(input mvma_pkg::op_t op,
                                            input logic [mvma_pkg::COL_W-1:0] base,
                                            input mvma_pkg::elem_t lanes [mvma_pkg::LANES],
                                            input logic signed [mvma_pkg::Y_W-1:0] y_old,
                                            input logic last);
        logic [mvma_pkg::COL_W-1:0] col;
        longint           dot;
        longint           wide;
        longint           rounded;
        row_result_t      res;
        dot = 0;
        if (op == mvma_pkg::OP_LOAD)
        begin
            for (int k = 0; k < mvma_pkg::LANES; k++)
            begin
                col = base + mvma_pkg::COL_W'(k);
                x_shadow[col] = lanes[k];
                x_written[col] = 1'b1;
            end
            row_count = '0;
            last_load_base = base;
            return;
        end
        for (int k = 0; k < mvma_pkg::LANES; k++)
        begin
            col = base + mvma_pkg::COL_W'(k);
            dot += longint'(lanes[k]) * longint'(x_shadow[col]);
        end
        row_acc = row_acc + mvma_pkg::ACC_W'(dot);
        if (!last)
            return;
        wide = longint'(alpha_q) * longint'(row_acc) + longint'(beta_q) * longint'(y_old);
        rounded = (wide + 128) >>> mvma_pkg::FRAC_SHIFT;
        res.saturated = 1'b0;
        if (rounded > CLAMP_HI)
        begin
            rounded = CLAMP_HI;
            res.saturated = 1'b1;
        end
        else if (rounded < CLAMP_LO)
        begin
            rounded = CLAMP_LO;
            res.saturated = 1'b1;
        end
        res.y_new = mvma_pkg::Y_W'(rounded);
        res.row_number = row_count;
        y_expect_q.push_back(res);
        row_acc = '0;
        row_count = row_count + 1'b1;
    endfunction

    function automatic bit cols_loaded(input logic [mvma_pkg::COL_W-1:0] base);
        for (int k = 0; k < mvma_pkg::LANES; k++)
            if (!x_written[base + mvma_pkg::COL_W'(k)])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic mvma_pkg::elem_t rand_elem();
        mvma_pkg::elem_t pick [4];
        pick = '{E_MIN, E_MAX, 16'sd0, -16'sd1};
        case ($urandom_range(0, 7))
            0: return pick[$urandom_range(0, 3)];
            1, 2: return mvma_pkg::elem_t'($urandom);
            default: return mvma_pkg::elem_t'(int'($urandom_range(0, 2047)) - 1024);
        endcase
    endfunction

    function automatic logic signed [mvma_pkg::COEF_W-1:0] rand_coef();
        logic signed [mvma_pkg::COEF_W-1:0] pick [5];
        pick = '{C_MIN, C_MAX, 16'sd0, 16'sd256, -16'sd256};
        case ($urandom_range(0, 3))
            0: return pick[$urandom_range(0, 4)];
            1: return mvma_pkg::COEF_W'($urandom);
            default: return mvma_pkg::COEF_W'(int'($urandom_range(0, 1023)) - 512);
        endcase
    endfunction

    function automatic logic signed [mvma_pkg::Y_W-1:0] rand_y();
        case ($urandom_range(0, 3))
            0: return ($urandom_range(0, 1) != 0) ? Y_MAX : Y_MIN;
            1: return mvma_pkg::Y_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return mvma_pkg::Y_W'($urandom);
        endcase
    endfunction

    // one item beat; valid stays high on return so back-to-back beats need no toggle
    task automatic send_beat(input mvma_pkg::op_t op, input logic [mvma_pkg::COL_W-1:0] base,
                             input mvma_pkg::elem_t e0, input mvma_pkg::elem_t e1,
                             input mvma_pkg::elem_t e2, input mvma_pkg::elem_t e3,
                             input logic signed [mvma_pkg::Y_W-1:0] y_old, input logic last);
        mvma_pkg::elem_t lanes [mvma_pkg::LANES];
        lanes = '{e0, e1, e2, e3};
        if (src_gaps && $urandom_range(0, 4) == 0)
        begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_bus.valid    <= 1'b1;
        item_bus.opcode   <= op;
        item_bus.col_base <= base;
        item_bus.elem0    <= e0;
        item_bus.elem1    <= e1;
        item_bus.elem2    <= e2;
        item_bus.elem3    <= e3;
        item_bus.y_old    <= y_old;
        item_bus.row_last <= last;
        do @(posedge clk); while (item_bus.ready !== 1'b1);
        apply_gemv_beat(op, base, lanes, y_old, last);
        beats_sent++;
    endtask

    task automatic send_rand_beat(input mvma_pkg::op_t op,
                                  input logic [mvma_pkg::COL_W-1:0] base, input logic last);
        send_beat(op, base, rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_y(), last);
    endtask

    task automatic drain_results();
        item_bus.valid <= 1'b0;
        while (y_expect_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    // only called with the item channel drained
    task automatic write_coefs(input logic signed [mvma_pkg::COEF_W-1:0] alpha_v,
                               input logic signed [mvma_pkg::COEF_W-1:0] beta_v);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= mvma_pkg::REG_ALPHA;
        cfg_bus.data  <= alpha_v;
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
        alpha_q = alpha_v;
        cfg_bus.index <= mvma_pkg::REG_BETA;
        cfg_bus.data  <= beta_v;
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
        beta_q = beta_v;
        cfg_bus.valid <= 1'b0;
    endtask

    // result side: checks each beat and stalls ready in short bursts
    initial
    begin : result_sink
        int unsigned stall_left;
        row_result_t want;
        stall_left = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            begin
                if (y_expect_q.size() == 0)
                begin
                    fail_count++;
                    $error("unexpected result beat: y_new %0d row_number %0d",
                           result_bus.y_new, result_bus.row_number);
                end
                else
                begin
                    want = y_expect_q.pop_front();
                    if (result_bus.y_new !== want.y_new)
                    begin
                        fail_count++;
                        $error("y_new: expected %0d, got %0d", want.y_new, result_bus.y_new);
                    end
                    if (result_bus.row_number !== want.row_number)
                    begin
                        fail_count++;
                        $error("row_number: expected %0d, got %0d",
                               want.row_number, result_bus.row_number);
                    end
                    if (result_bus.saturated !== want.saturated)
                    begin
                        fail_count++;
                        $error("saturated: expected %0b, got %0b",
                               want.saturated, result_bus.saturated);
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else if (snk_gaps && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    task automatic test_extremes();
        send_beat(mvma_pkg::OP_LOAD, 8'd0, E_MIN, E_MAX, 16'sd0, -16'sd1, Y_MAX, 1'b1);
        send_beat(mvma_pkg::OP_LOAD, 8'd4, E_MIN, E_MIN, E_MIN, E_MIN, Y_MIN, 1'b0);
        // full positive and full negative products push past the output range
        send_beat(mvma_pkg::OP_ROW, 8'd4, E_MIN, E_MIN, E_MIN, E_MIN, 32'sd0, 1'b1);
        send_beat(mvma_pkg::OP_ROW, 8'd4, E_MAX, E_MAX, E_MAX, E_MAX, 32'sd0, 1'b1);
        send_beat(mvma_pkg::OP_ROW, 8'd0, E_MAX, E_MIN, -16'sd1, 16'sd0, Y_MIN, 1'b0);
        send_beat(mvma_pkg::OP_ROW, 8'd0, 16'sd1, 16'sd1, 16'sd1, 16'sd1, Y_MAX, 1'b1);
        // unaligned base wraps past the top column
        send_beat(mvma_pkg::OP_LOAD, 8'd254, 16'sd256, -16'sd256, 16'sd512, -16'sd512,
                  32'sd0, 1'b0);
        send_beat(mvma_pkg::OP_ROW, 8'd254, 16'sd256, 16'sd256, 16'sd256, 16'sd256,
                  32'sd77, 1'b1);
        send_beat(mvma_pkg::OP_ROW, 8'd255, 16'sd3, -16'sd5, 16'sd7, E_MAX, 32'sd1, 1'b1);
    endtask

    task automatic test_coef_extremes();
        drain_results();
        write_coefs(C_MIN, C_MAX);
        send_beat(mvma_pkg::OP_ROW, 8'd0, 16'sd256, -16'sd256, 16'sd16, E_MAX, Y_MIN, 1'b1);
        send_beat(mvma_pkg::OP_ROW, 8'd4, 16'sd1, -16'sd1, 16'sd2, -16'sd2, Y_MAX, 1'b1);
        drain_results();
        write_coefs(C_MAX, C_MIN);
        send_beat(mvma_pkg::OP_ROW, 8'd0, 16'sd256, -16'sd256, 16'sd16, E_MAX, Y_MIN, 1'b1);
        send_beat(mvma_pkg::OP_ROW, 8'd4, 16'sd1, -16'sd1, 16'sd2, -16'sd2, Y_MAX, 1'b1);
        drain_results();
        write_coefs(16'sd0, 16'sd0);
        send_beat(mvma_pkg::OP_ROW, 8'd254, E_MIN, E_MIN, E_MIN, E_MIN, Y_MAX, 1'b1);
    endtask

    task automatic test_row_counter_clear();
        drain_results();
        write_coefs(16'sd256, 16'sd256);
        repeat (3)
            send_beat(mvma_pkg::OP_ROW, 8'd4, 16'sd2, 16'sd3, -16'sd4, 16'sd5,
                      32'sd65536, 1'b1);
        send_beat(mvma_pkg::OP_ROW, 8'd0, 16'sd9, 16'sd8, 16'sd7, 16'sd6, 32'sd0, 1'b0);
        // a load clears the row count but keeps the partial row sum
        send_beat(mvma_pkg::OP_LOAD, 8'd8, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 32'sd0, 1'b1);
        send_beat(mvma_pkg::OP_ROW, 8'd8, 16'sd256, 16'sd256, 16'sd256, 16'sd256,
                  -32'sd65536, 1'b1);
    endtask

    // one x vector load followed by whole rows over the same columns
    task automatic gemv_sequence();
        int unsigned      groups;
        int unsigned      rows;
        logic [mvma_pkg::COL_W-1:0] start;
        groups = $urandom_range(1, 4);
        rows = $urandom_range(1, 5);
        if ($urandom_range(0, 7) == 0)
            start = mvma_pkg::COL_W'($urandom_range(0, mvma_pkg::MAX_COLS - 1));
        else
            start = mvma_pkg::COL_W'($urandom_range(0, mvma_pkg::BANK_DEPTH - 1)
                                     * mvma_pkg::LANES);
        for (int unsigned g = 0; g < groups; g++)
            send_rand_beat(mvma_pkg::OP_LOAD, start + mvma_pkg::COL_W'(g * mvma_pkg::LANES),
                           1'($urandom));
        for (int unsigned r = 0; r < rows; r++)
            for (int unsigned g = 0; g < groups; g++)
                send_rand_beat(mvma_pkg::OP_ROW,
                               start + mvma_pkg::COL_W'(g * mvma_pkg::LANES),
                               g == groups - 1);
    endtask

    task automatic noise_beat();
        logic [mvma_pkg::COL_W-1:0] base;
        base = mvma_pkg::COL_W'($urandom);
        if ($urandom_range(0, 2) == 0)
            send_rand_beat(mvma_pkg::OP_LOAD, base, 1'($urandom));
        else
        begin
            if (!cols_loaded(base))
                base = last_load_base;
            send_rand_beat(mvma_pkg::OP_ROW, base, 1'($urandom));
        end
    endtask

    task automatic test_random_gemv();
        int unsigned first;
        int unsigned phase_end;
        first = beats_sent;
        while (beats_sent - first < RANDOM_BEATS)
        begin
            drain_results();
            write_coefs(rand_coef(), rand_coef());
            src_gaps = ($urandom_range(0, 3) != 0);
            snk_gaps = ($urandom_range(0, 3) != 0);
            phase_end = beats_sent - first + $urandom_range(60, 140);
            while (beats_sent - first < phase_end && beats_sent - first < RANDOM_BEATS)
            begin
                if (beats_sent - first >= RANDOM_BEATS - QUIET_TAIL)
                begin
                    src_gaps = 1'b0;
                    snk_gaps = 1'b0;
                end
                if ($urandom_range(0, 6) != 0)
                    gemv_sequence();
                else
                    noise_beat();
            end
        end
    endtask

    initial
    begin
        fail_count = 0;
        beats_sent = 0;
        cycle_count = 0;
        src_gaps = 1'b1;
        snk_gaps = 1'b1;
        row_acc = '0;
        row_count = '0;
        alpha_q = mvma_pkg::ALPHA_RESET;
        beta_q = mvma_pkg::BETA_RESET;
        last_load_base = '0;
        for (int i = 0; i < mvma_pkg::MAX_COLS; i++)
        begin
            x_shadow[i] = '0;
            x_written[i] = 1'b0;
        end
        rst_n             <= 1'b0;
        item_bus.valid    <= 1'b0;
        item_bus.opcode   <= mvma_pkg::OP_LOAD;
        item_bus.col_base <= '0;
        item_bus.elem0    <= '0;
        item_bus.elem1    <= '0;
        item_bus.elem2    <= '0;
        item_bus.elem3    <= '0;
        item_bus.y_old    <= '0;
        item_bus.row_last <= 1'b0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= mvma_pkg::REG_ALPHA;
        cfg_bus.data      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_coef_extremes();
        test_row_counter_clear();
        test_random_gemv();
        drain_results();

        if (fail_count == 0)
            $display("PASS matrix_vector_multiply_accumulate_unit");
        else
            $display("FAIL matrix_vector_multiply_accumulate_unit");
        $finish;
    end

endmodule

@@ matrix_vector_multiply_accumulate_unit.f @@
design/mvma_pkg.sv
design/mvma_chan_if.sv
design/mvma_xbank.sv
design/mvma_lane.sv
design/mvma_merge.sv
design/matrix_vector_multiply_accumulate_unit.sv
tb/sv/tb_matrix_vector_multiply_accumulate_unit.sv
